@@ src/hsvrgb_pkg.sv @@
// Shared types and constants for the HSV to RGB pixel converter.
// Holds the input and output word structs, the fixed-point constants and the sector codes.
// No dependencies.
package hsvrgb_pkg;

    // Hue scale: sixteenths of a degree.
    localparam int HUE_W       = 13;
    localparam int FRAC_W      = 10;
    localparam int CHAN_W      = 8;
    localparam int BRIGHT_W    = 5;

    localparam int HUE_SECTOR  = 960;                    // 60 degrees
    localparam int HUE_FULL    = 6 * HUE_SECTOR;         // 360 degrees
    localparam int UNIT        = 255;                    // 1.0 in an 8-bit fraction
    localparam int SECTOR_UNIT = UNIT * HUE_SECTOR;      // 244800, divisor for q and t

    // Width of saturation times sector fraction, and of value times that.
    localparam int SF_W        = 18;
    localparam int QT_PROD_W   = SF_W + CHAN_W;          // 26

    // q and t divide by 255*960 = 64 * 3825: shift by 6, then reciprocal of 3825.
    localparam int QT_PRE_SHIFT = 6;
    localparam int QT_DIV_W     = QT_PROD_W - QT_PRE_SHIFT;  // 20
    localparam int QT_RECIP_W   = 21;
    localparam int QT_RECIP_SH  = 32;
    localparam logic [QT_RECIP_W-1:0] QT_RECIP = 21'd1122868;  // ceil(2^32 / 3825)

    // p divides a 16-bit product by 255 through a reciprocal.
    localparam int P_PROD_W    = 2 * CHAN_W;             // 16
    localparam int P_RECIP_W   = 17;
    localparam int P_RECIP_SH  = 24;
    localparam logic [P_RECIP_W-1:0] P_RECIP = 17'd65794;      // ceil(2^24 / 255)

    // Hue sectors of the six-sector method.
    typedef enum logic [2:0] {
        SECTOR_RED_YEL = 3'd0,
        SECTOR_YEL_GRN = 3'd1,
        SECTOR_GRN_CYN = 3'd2,
        SECTOR_CYN_BLU = 3'd3,
        SECTOR_BLU_MAG = 3'd4,
        SECTOR_MAG_RED = 3'd5
    } sector_t;

    // Input word: one HSV pixel.
    typedef struct packed {
        logic [HUE_W-1:0]    hue;
        logic [CHAN_W-1:0]   saturation;
        logic [CHAN_W-1:0]   value;
        logic [BRIGHT_W-1:0] brightness;
    } hsv_word_t;

    // Output word: one RGB pixel with the brightness code.
    typedef struct packed {
        logic [CHAN_W-1:0]   red;
        logic [CHAN_W-1:0]   green;
        logic [CHAN_W-1:0]   blue;
        logic [BRIGHT_W-1:0] brightness_out;
    } rgb_word_t;

endpackage

@@ src/hsv_to_rgb_pixel.sv @@
// HSV to RGB pixel converter, four-stage pipeline with valid bits per stage.
// Throughput: one word per cycle; each stage holds when the stage after it is full and stalled.
// Reset: rst_n clears all stage valid bits asynchronously; payload registers are not reset.
// Depends on hsvrgb_pkg.
module hsv_to_rgb_pixel (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  pixel_valid,
    output logic                  pixel_ready,
    input  hsvrgb_pkg::hsv_word_t pixel,
    output logic                  rgb_valid,
    input  logic                  rgb_ready,
    output hsvrgb_pkg::rgb_word_t rgb
);
    import hsvrgb_pkg::*;

    localparam logic [HUE_W-1:0]  HUE_FULL_C   = HUE_W'(HUE_FULL);
    localparam logic [FRAC_W-1:0] HUE_SECTOR_C = FRAC_W'(HUE_SECTOR);
    localparam logic [SF_W-1:0]   SECTOR_UNIT_C = SF_W'(SECTOR_UNIT);
    localparam logic [CHAN_W-1:0] UNIT_C       = CHAN_W'(UNIT);

    // Stage valid bits and advance enables.
    logic v1_reg, v2_reg, v3_reg, v4_reg;
    logic en1, en2, en3, en4;

    assign en4 = !v4_reg || rgb_ready;
    assign en3 = !v3_reg || en4;
    assign en2 = !v2_reg || en3;
    assign en1 = !v1_reg || en2;
    assign pixel_ready = en1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
        end
        else
        begin
            if (en1) v1_reg <= pixel_valid;
            if (en2) v2_reg <= v1_reg;
            if (en3) v3_reg <= v2_reg;
            if (en4) v4_reg <= v3_reg;
        end
    end

    // ---------------- Stage 1: sector, fraction and the p product ----------------
    logic [HUE_W-1:0]    hue_w;
    sector_t             sector_next;
    logic [HUE_W-1:0]    base_next;
    logic [HUE_W-1:0]    frac_full;
    logic [FRAC_W-1:0]   frac_next;
    logic [P_PROD_W-1:0] pn_next;

    sector_t             s1_sector_reg;
    logic [FRAC_W-1:0]   s1_frac_reg;
    logic [P_PROD_W-1:0] s1_pn_reg;
    logic [CHAN_W-1:0]   s1_sat_reg;
    logic [CHAN_W-1:0]   s1_val_reg;
    logic [BRIGHT_W-1:0] s1_bright_reg;

    // A hue of a full turn or more counts as zero.
    assign hue_w = (pixel.hue >= HUE_FULL_C) ? '0 : pixel.hue;

    // The sector comes from compares against the sector boundaries.
    always_comb
    begin
        priority if (hue_w >= HUE_W'(5 * HUE_SECTOR))
        begin
            sector_next = SECTOR_MAG_RED;
            base_next   = HUE_W'(5 * HUE_SECTOR);
        end
        else if (hue_w >= HUE_W'(4 * HUE_SECTOR))
        begin
            sector_next = SECTOR_BLU_MAG;
            base_next   = HUE_W'(4 * HUE_SECTOR);
        end
        else if (hue_w >= HUE_W'(3 * HUE_SECTOR))
        begin
            sector_next = SECTOR_CYN_BLU;
            base_next   = HUE_W'(3 * HUE_SECTOR);
        end
        else if (hue_w >= HUE_W'(2 * HUE_SECTOR))
        begin
            sector_next = SECTOR_GRN_CYN;
            base_next   = HUE_W'(2 * HUE_SECTOR);
        end
        else if (hue_w >= HUE_W'(HUE_SECTOR))
        begin
            sector_next = SECTOR_YEL_GRN;
            base_next   = HUE_W'(HUE_SECTOR);
        end
        else
        begin
            sector_next = SECTOR_RED_YEL;
            base_next   = '0;
        end
    end

    assign frac_full = hue_w - base_next;
    assign frac_next = frac_full[FRAC_W-1:0];

    // The p numerator is value times (1 - saturation).
    assign pn_next = P_PROD_W'(pixel.value) * P_PROD_W'(UNIT_C - pixel.saturation);

    always_ff @(posedge clk)
    begin
        if (en1)
        begin
            s1_sector_reg <= sector_next;
            s1_frac_reg   <= frac_next;
            s1_pn_reg     <= pn_next;
            s1_sat_reg    <= pixel.saturation;
            s1_val_reg    <= pixel.value;
            s1_bright_reg <= pixel.brightness;
        end
    end

    // ---------------- Stage 2: saturation times fraction, p divided by 255 ----------------
    logic [SF_W-1:0]                 sf_next;
    logic [SF_W-1:0]                 sg_next;
    logic [P_PROD_W+P_RECIP_W-1:0]   pm;
    logic [CHAN_W-1:0]               p_next;

    sector_t             s2_sector_reg;
    logic [SF_W-1:0]     s2_sf_reg;
    logic [SF_W-1:0]     s2_sg_reg;
    logic [CHAN_W-1:0]   s2_p_reg;
    logic [CHAN_W-1:0]   s2_val_reg;
    logic [BRIGHT_W-1:0] s2_bright_reg;

    assign sf_next = SF_W'(s1_sat_reg) * SF_W'(s1_frac_reg);
    assign sg_next = SF_W'(s1_sat_reg) * SF_W'(HUE_SECTOR_C - s1_frac_reg);

    // Multiply by the reciprocal of 255; exact for every 16-bit numerator in range.
    assign pm     = (P_PROD_W + P_RECIP_W)'(s1_pn_reg) * (P_PROD_W + P_RECIP_W)'(P_RECIP);
    assign p_next = pm[P_RECIP_SH +: CHAN_W];

    always_ff @(posedge clk)
    begin
        if (en2)
        begin
            s2_sector_reg <= s1_sector_reg;
            s2_sf_reg     <= sf_next;
            s2_sg_reg     <= sg_next;
            s2_p_reg      <= p_next;
            s2_val_reg    <= s1_val_reg;
            s2_bright_reg <= s1_bright_reg;
        end
    end

    // ---------------- Stage 3: value times the q and t numerators ----------------
    logic [SF_W-1:0]      nq, nt;
    logic [QT_PROD_W-1:0] xq, xt;

    sector_t              s3_sector_reg;
    logic [QT_DIV_W-1:0]  s3_yq_reg;
    logic [QT_DIV_W-1:0]  s3_yt_reg;
    logic [CHAN_W-1:0]    s3_p_reg;
    logic [CHAN_W-1:0]    s3_val_reg;
    logic [BRIGHT_W-1:0]  s3_bright_reg;

    assign nq = SECTOR_UNIT_C - s2_sf_reg;
    assign nt = SECTOR_UNIT_C - s2_sg_reg;
    assign xq = QT_PROD_W'(s2_val_reg) * QT_PROD_W'(nq);
    assign xt = QT_PROD_W'(s2_val_reg) * QT_PROD_W'(nt);

    // Dropping the low six bits divides by 64, the power-of-two part of 255*960.
    always_ff @(posedge clk)
    begin
        if (en3)
        begin
            s3_sector_reg <= s2_sector_reg;
            s3_yq_reg     <= xq[QT_PRE_SHIFT +: QT_DIV_W];
            s3_yt_reg     <= xt[QT_PRE_SHIFT +: QT_DIV_W];
            s3_p_reg      <= s2_p_reg;
            s3_val_reg    <= s2_val_reg;
            s3_bright_reg <= s2_bright_reg;
        end
    end

    // ---------------- Stage 4: divide by 3825 and pick channels by sector ----------------
    localparam int QT_MUL_W = QT_DIV_W + QT_RECIP_W;

    logic [QT_MUL_W-1:0] qm, tm;
    logic [CHAN_W-1:0]   q_val, t_val;
    rgb_word_t           rgb_next;
    rgb_word_t           rgb_reg;

    assign qm    = QT_MUL_W'(s3_yq_reg) * QT_MUL_W'(QT_RECIP);
    assign tm    = QT_MUL_W'(s3_yt_reg) * QT_MUL_W'(QT_RECIP);
    assign q_val = qm[QT_RECIP_SH +: CHAN_W];
    assign t_val = tm[QT_RECIP_SH +: CHAN_W];

    // Zero saturation makes p, q and t equal value, so grey needs no separate path.
    always_comb
    begin
        rgb_next.brightness_out = s3_bright_reg;
        unique case (s3_sector_reg)
            SECTOR_RED_YEL:
            begin
                rgb_next.red = s3_val_reg; rgb_next.green = t_val; rgb_next.blue = s3_p_reg;
            end
            SECTOR_YEL_GRN:
            begin
                rgb_next.red = q_val; rgb_next.green = s3_val_reg; rgb_next.blue = s3_p_reg;
            end
            SECTOR_GRN_CYN:
            begin
                rgb_next.red = s3_p_reg; rgb_next.green = s3_val_reg; rgb_next.blue = t_val;
            end
            SECTOR_CYN_BLU:
            begin
                rgb_next.red = s3_p_reg; rgb_next.green = q_val; rgb_next.blue = s3_val_reg;
            end
            SECTOR_BLU_MAG:
            begin
                rgb_next.red = t_val; rgb_next.green = s3_p_reg; rgb_next.blue = s3_val_reg;
            end
            default:
            begin
                rgb_next.red = s3_val_reg; rgb_next.green = s3_p_reg; rgb_next.blue = q_val;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (en4)
        begin
            rgb_reg <= rgb_next;
        end
    end

    assign rgb_valid = v4_reg;
    assign rgb       = rgb_reg;

endmodule
